FILE: rtl/core/pfa_pkg.sv
// ============================================================================
// pfa_pkg: shared types and constants of the partition fit allocator
// Word layouts, operation and status codes, controller/datapath interface.
// ============================================================================
`timescale 1ns / 1ps

package pfa_pkg;

    localparam int FUNC_W     = 2;
    localparam int AMT_W      = 31;
    localparam int SLOT_W     = 2;
    localparam int STAT_W     = 3;
    localparam int START_W    = 31;
    localparam int SPACE_W    = 31;
    localparam int MODE_W     = 2;
    localparam int BASE_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    // register reset values
    localparam logic [SPACE_W-1:0] SPACE_RST = 31'd1048576;
    localparam logic [MODE_W-1:0]  MODE_RST  = 2'd1;
    localparam logic [BASE_W-1:0]  BASE_RST  = 16'd128;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SPACE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE  = 2'd2;

    // placement policy; the unused code behaves as first fit
    localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CREATE = 2'd0,
        FUNC_DELETE = 2'd1,
        FUNC_GROW   = 2'd2,
        FUNC_NOP    = 2'd3
    } pfa_func_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK         = 3'd0,
        ST_NO_GAP     = 3'd1,
        ST_FULL       = 3'd2,
        ST_SECOND_EXT = 3'd3,
        ST_INACTIVE   = 3'd4,
        ST_LIMIT      = 3'd5
    } pfa_status_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [AMT_W-1:0]  amount;
        logic              is_extended;
        logic [SLOT_W-1:0] slot;
    } pfa_in_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [START_W-1:0] placed_start;
        logic [SLOT_W-1:0]  placed_slot;
    } pfa_out_t;

    // datapath operations issued by the controller
    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_LATCH  = 3'd1,
        OP_DECODE = 3'd2,
        OP_SCAN   = 3'd3,
        OP_PLACE  = 3'd4,
        OP_GSUM   = 3'd5,
        OP_GEND   = 3'd6,
        OP_GCHK   = 3'd7
    } pfa_op_t;

    typedef struct packed {
        pfa_op_t op;
        logic    load_out;
    } pfa_cmd_t;

    typedef struct packed {
        pfa_func_t func;
        logic      pre_err;
        logic      scan_done;
    } pfa_stat_t;

endpackage

FILE: rtl/core/pfa_ctrl.sv
// ============================================================================
// pfa_ctrl: request sequencer of the partition fit allocator
// Steps the datapath through decode, gap scan, placement or grow check.
// ============================================================================
`timescale 1ns / 1ps

module pfa_ctrl import pfa_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  pfa_stat_t stat,
    output pfa_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_SCAN, S_PLACE, S_GSUM, S_GEND, S_GCHK, S_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   out_vld_reg, out_vld_next;

    always_comb begin
        state_next   = state_reg;
        out_vld_next = out_vld_reg;
        cmd          = '{op: OP_NONE, load_out: 1'b0};
        if (out_vld_reg && m_ready) begin
            out_vld_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op     = OP_LATCH;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.op = OP_DECODE;
                if (!stat.pre_err && stat.func == FUNC_CREATE) begin
                    state_next = S_SCAN;
                end else if (!stat.pre_err && stat.func == FUNC_GROW) begin
                    state_next = S_GSUM;
                end else begin
                    state_next = S_RESULT;
                end
            end
            S_SCAN: begin
                cmd.op = OP_SCAN;
                if (stat.scan_done) begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE: begin
                cmd.op     = OP_PLACE;
                state_next = S_RESULT;
            end
            S_GSUM: begin
                cmd.op     = OP_GSUM;
                state_next = S_GEND;
            end
            S_GEND: begin
                cmd.op     = OP_GEND;
                state_next = S_GCHK;
            end
            S_GCHK: begin
                cmd.op     = OP_GCHK;
                state_next = S_RESULT;
            end
            S_RESULT: begin
                // wait for the output register to free up
                if (!out_vld_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    out_vld_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = out_vld_reg;

endmodule

FILE: rtl/core/pfa_datapath.sv
// ============================================================================
// pfa_datapath: region table, gap scanner and grow checker
// Holds the sorted table, the configuration and the result registers.
// ============================================================================
`timescale 1ns / 1ps

module pfa_datapath import pfa_pkg::*; #(
    parameter int SLOTS     = 4,
    parameter int ADDR_BITS = 31
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  pfa_cmd_t              cmd,
    output pfa_stat_t             stat,
    input  pfa_in_t               s_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output pfa_out_t              m_data
);

    localparam int SW = $clog2(SLOTS);
    localparam int IW = $clog2(SLOTS + 2);
    localparam int PW = ((ADDR_BITS > SPACE_W) ? ADDR_BITS : SPACE_W) + 1;
    localparam int EW = PW + 1;

    typedef struct packed {
        logic                 active;
        logic [ADDR_BITS-1:0] start;
        logic [ADDR_BITS-1:0] size;
        logic                 ext;
    } entry_t;

    entry_t              tbl_reg [SLOTS];
    entry_t              tbl_next[SLOTS];
    logic [SPACE_W-1:0]  space_reg, space_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [BASE_W-1:0]   base_reg, base_next;
    pfa_in_t             req_reg, req_next;
    pfa_out_t            res_reg, res_next;
    pfa_out_t            out_reg, out_next;

    // gap scan
    logic [IW-1:0]       scan_idx_reg, scan_idx_next;
    logic [PW-1:0]       prev_reg, prev_next;
    logic                gap_vld_reg, gap_vld_next;
    logic [PW-1:0]       gap_start_reg, gap_start_next;
    logic [PW-1:0]       gap_len_reg, gap_len_next;
    logic                found_reg, found_next;
    logic [PW-1:0]       best_start_reg, best_start_next;
    logic [PW-1:0]       best_len_reg, best_len_next;

    // grow
    logic [PW-1:0]        sum_reg, sum_next;
    logic [ADDR_BITS-1:0] cur_start_reg, cur_start_next;
    logic [EW-1:0]        end_reg, end_next;
    logic                 nxt_vld_reg, nxt_vld_next;
    logic [ADDR_BITS-1:0] nxt_start_reg, nxt_start_next;

    // indexed table read port
    logic [SW-1:0]  rd_idx;
    entry_t         rd_entry;
    logic [SW-1:0]  slot_idx;
    logic [SW:0]    slot_p1;
    logic           slot_ok;
    logic           nxt_in_range;

    logic [SLOTS-1:0]     act_vec;
    logic [SLOTS-1:0]     ext_vec;
    logic [SLOTS-1:0]     le_vec;
    logic                 tbl_full;
    logic                 have_ext;
    logic                 idx_lt;
    logic                 idx_eq;
    logic [PW-1:0]        ent_end;
    logic [PW-1:0]        g_lim;
    logic [PW-1:0]        g_len;
    logic                 take;
    logic                 better;
    logic [ADDR_BITS-1:0] new_start;
    logic [SW:0]          ins_pos;
    entry_t               new_ent;
    logic                 grow_fail;

    assign slot_idx     = SW'(req_reg.slot);
    assign slot_p1      = (SW+1)'(slot_idx) + (SW+1)'(1);
    assign nxt_in_range = int'(slot_p1) < SLOTS;

    always_comb begin
        case (cmd.op)
            OP_SCAN: rd_idx = scan_idx_reg[SW-1:0];
            OP_GEND: rd_idx = slot_p1[SW-1:0];
            default: rd_idx = slot_idx;
        endcase
    end

    assign rd_entry = tbl_reg[rd_idx];
    assign slot_ok  = (int'(req_reg.slot) < SLOTS) && rd_entry.active;

    always_comb begin
        for (int j = 0; j < SLOTS; j++) begin
            act_vec[j] = tbl_reg[j].active;
            ext_vec[j] = tbl_reg[j].active && tbl_reg[j].ext;
            le_vec[j]  = tbl_reg[j].active && (tbl_reg[j].start <= new_start);
        end
    end

    assign tbl_full = &act_vec;
    assign have_ext = |ext_vec;

    // stage one of the scan: gap ahead of the entry, or the tail gap
    assign idx_lt  = int'(scan_idx_reg) < SLOTS;
    assign idx_eq  = int'(scan_idx_reg) == SLOTS;
    assign ent_end = PW'(rd_entry.start) + PW'(rd_entry.size);
    assign g_lim   = idx_lt ? PW'(rd_entry.start) : PW'(space_reg);
    assign g_len   = (g_lim > prev_reg) ? (g_lim - prev_reg) : '0;

    // stage two: fit decision on the registered gap
    assign take   = gap_vld_reg && (gap_len_reg >= PW'(req_reg.amount));
    assign better = ((mode_reg == FIT_BEST) && (gap_len_reg < best_len_reg)) ||
                    ((mode_reg == FIT_WORST) && (gap_len_reg > best_len_reg));

    // insertion point keeps the table sorted, equal starts stay ahead
    assign new_start = best_start_reg[ADDR_BITS-1:0];
    assign ins_pos   = (SW+1)'($countones(le_vec));
    assign new_ent   = '{active: 1'b1,
                         start:  new_start,
                         size:   ADDR_BITS'(PW'(req_reg.amount)),
                         ext:    req_reg.is_extended};

    assign grow_fail = (nxt_vld_reg && (end_reg > EW'(nxt_start_reg))) ||
                       (end_reg > EW'(space_reg));

    always_comb begin
        case (pfa_func_t'(req_reg.func))
            FUNC_CREATE: stat.pre_err = (req_reg.is_extended && have_ext) || tbl_full ||
                                        (req_reg.amount == '0);
            FUNC_DELETE: stat.pre_err = !slot_ok;
            FUNC_GROW:   stat.pre_err = !slot_ok;
            default:     stat.pre_err = 1'b1;
        endcase
        stat.func      = pfa_func_t'(req_reg.func);
        stat.scan_done = int'(scan_idx_reg) == (SLOTS + 1);
    end

    always_comb begin
        tbl_next        = tbl_reg;
        space_next      = space_reg;
        mode_next       = mode_reg;
        base_next       = base_reg;
        req_next        = req_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        scan_idx_next   = scan_idx_reg;
        prev_next       = prev_reg;
        gap_vld_next    = gap_vld_reg;
        gap_start_next  = gap_start_reg;
        gap_len_next    = gap_len_reg;
        found_next      = found_reg;
        best_start_next = best_start_reg;
        best_len_next   = best_len_reg;
        sum_next        = sum_reg;
        cur_start_next  = cur_start_reg;
        end_next        = end_reg;
        nxt_vld_next    = nxt_vld_reg;
        nxt_start_next  = nxt_start_reg;

        case (cmd.op)
            OP_LATCH: begin
                req_next = s_data;
            end
            OP_DECODE: begin
                res_next      = '0;
                scan_idx_next = '0;
                prev_next     = PW'(base_reg);
                gap_vld_next  = 1'b0;
                found_next    = 1'b0;
                case (pfa_func_t'(req_reg.func))
                    FUNC_CREATE: begin
                        if (req_reg.is_extended && have_ext) begin
                            res_next.status = ST_SECOND_EXT;
                        end else if (tbl_full) begin
                            res_next.status = ST_FULL;
                        end else if (req_reg.amount == '0) begin
                            res_next.status = ST_NO_GAP;
                        end
                    end
                    FUNC_DELETE: begin
                        if (!slot_ok) begin
                            res_next.status = ST_INACTIVE;
                        end else begin
                            res_next.placed_start = START_W'(rd_entry.start);
                            res_next.placed_slot  = req_reg.slot;
                            // close the hole, free entries stay zero
                            for (int j = 0; j < SLOTS - 1; j++) begin
                                if (j >= int'(slot_idx)) begin
                                    tbl_next[j] = tbl_reg[j+1];
                                end
                            end
                            tbl_next[SLOTS-1] = '0;
                        end
                    end
                    FUNC_GROW: begin
                        if (!slot_ok) begin
                            res_next.status = ST_INACTIVE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            OP_SCAN: begin
                scan_idx_next = scan_idx_reg + IW'(1);
                if (idx_lt || idx_eq) begin
                    gap_vld_next   = idx_lt ? rd_entry.active : 1'b1;
                    gap_start_next = prev_reg;
                    gap_len_next   = g_len;
                    if (idx_lt && rd_entry.active && (ent_end > prev_reg)) begin
                        prev_next = ent_end;
                    end
                end else begin
                    gap_vld_next = 1'b0;
                end
                if (take) begin
                    if (!found_reg) begin
                        found_next      = 1'b1;
                        best_start_next = gap_start_reg;
                        best_len_next   = gap_len_reg;
                    end else if (better) begin
                        best_start_next = gap_start_reg;
                        best_len_next   = gap_len_reg;
                    end
                end
            end
            OP_PLACE: begin
                if (found_reg) begin
                    if (ins_pos == '0) begin
                        tbl_next[0] = new_ent;
                    end
                    for (int j = 1; j < SLOTS; j++) begin
                        if (j == int'(ins_pos)) begin
                            tbl_next[j] = new_ent;
                        end else if (j > int'(ins_pos)) begin
                            tbl_next[j] = tbl_reg[j-1];
                        end
                    end
                    res_next.status       = ST_OK;
                    res_next.placed_start = START_W'(best_start_reg);
                    res_next.placed_slot  = SLOT_W'(ins_pos);
                end else begin
                    res_next.status = ST_NO_GAP;
                end
            end
            OP_GSUM: begin
                sum_next       = PW'(rd_entry.size) + PW'(req_reg.amount);
                cur_start_next = rd_entry.start;
            end
            OP_GEND: begin
                end_next       = EW'(cur_start_reg) + EW'(sum_reg);
                nxt_vld_next   = nxt_in_range && rd_entry.active;
                nxt_start_next = rd_entry.start;
            end
            OP_GCHK: begin
                if (grow_fail) begin
                    res_next.status = ST_LIMIT;
                end else begin
                    tbl_next[slot_idx].size = sum_reg[ADDR_BITS-1:0];
                    res_next.status         = ST_OK;
                    res_next.placed_start   = START_W'(cur_start_reg);
                    res_next.placed_slot    = req_reg.slot;
                end
            end
            default: begin
            end
        endcase

        if (cmd.load_out) begin
            out_next = res_reg;
        end

        if (cfg_we) begin
            case (cfg_index)
                REG_SPACE: space_next = cfg_wdata[SPACE_W-1:0];
                REG_FIT:   mode_next  = cfg_wdata[MODE_W-1:0];
                REG_BASE:  base_next  = cfg_wdata[BASE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < SLOTS; j++) begin
                tbl_reg[j].active <= 1'b0;
            end
            space_reg <= SPACE_RST;
            mode_reg  <= MODE_RST;
            base_reg  <= BASE_RST;
        end else begin
            tbl_reg   <= tbl_next;
            space_reg <= space_next;
            mode_reg  <= mode_next;
            base_reg  <= base_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        res_reg        <= res_next;
        out_reg        <= out_next;
        scan_idx_reg   <= scan_idx_next;
        prev_reg       <= prev_next;
        gap_vld_reg    <= gap_vld_next;
        gap_start_reg  <= gap_start_next;
        gap_len_reg    <= gap_len_next;
        found_reg      <= found_next;
        best_start_reg <= best_start_next;
        best_len_reg   <= best_len_next;
        sum_reg        <= sum_next;
        cur_start_reg  <= cur_start_next;
        end_reg        <= end_next;
        nxt_vld_reg    <= nxt_vld_next;
        nxt_start_reg  <= nxt_start_next;
    end

    assign m_data = out_reg;

endmodule

FILE: rtl/core/partition_fit_allocator_unit.sv
// ============================================================================
// One request at a time; the gap scan of a create steps one table slot per cycle.
// Reset (aresetn low, synchronous): all slots inactive, registers to defaults.
// partition_fit_allocator_unit: region table allocator, top level
// ============================================================================
`timescale 1ns / 1ps

module partition_fit_allocator_unit import pfa_pkg::*; #(
    parameter int SLOTS     = 4,
    parameter int ADDR_BITS = 31
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // request words
    input  logic                  s_valid,
    output logic                  s_ready,
    input  pfa_in_t               s_data,
    // result words
    output logic                  m_valid,
    input  logic                  m_ready,
    output pfa_out_t              m_data,
    // configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // The controller walks one request at a time:
    //   decode   - operand checks; delete commits here (table compacts)
    //   scan     - each of the SLOTS+1 gaps is measured in one cycle and
    //              judged against the fit policy in the next
    //   place    - insert at the sorted position, later entries shift up
    //   grow     - size sum, new end, then bounds check against the next
    //              region and the end of the space
    //   result   - move into the output register once it is free
    // A request word is taken again as soon as the result is parked in the
    // output register, even while that word still waits for m_ready.

    pfa_cmd_t  cmd;
    pfa_stat_t stat;

    pfa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    pfa_datapath #(
        .SLOTS     (SLOTS),
        .ADDR_BITS (ADDR_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_data    (s_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_data    (m_data)
    );

    // one request in flight: no second accept right after the first
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while busy");

    // error results carry no placement
    a_err_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status != ST_OK)) |->
            ((m_data.placed_start == '0) && (m_data.placed_slot == '0)))
        else $error("error result with placement fields set");

    // a result never overwrites an unread one
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid || m_ready))
        else $error("output register overwritten");

endmodule
